// ----- rtl/hcbd_pkg.sv -----
// Shared types, character codes and helpers for the chunked body decoder.
// No dependencies; used by http_chunked_body_decoder, its checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package hcbd_pkg;

    // Sticky error codes reported on the error output.
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_SIZE_LINE = 3'd1,
        ERR_OVERFLOW  = 3'd2,
        ERR_SEPARATOR = 3'd3,
        ERR_AFTER_END = 3'd4
    } t_err;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // Decodes one ASCII hex digit of either case.
    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex r;
        r.ok  = 1'b0;
        r.val = c[3:0];
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r.ok = 1'b1;
        end else if ((c >= CH_A_LO && c <= CH_F_LO) || (c >= CH_A_UP && c <= CH_F_UP)) begin
            // Letters a..f sit at 0x1..0x6 in their low nibble.
            r.ok  = 1'b1;
            r.val = c[3:0] + 4'd9;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/http_chunked_body_decoder.sv -----
// Top level of the HTTP/1.1 chunked transfer body decoder.
// Depends on hcbd_pkg for character codes, error codes and hex decoding.
//
//  Channel  | Handshake                | Payload
//  ---------+--------------------------+---------------------------------------------
//  input    | i_in_valid / o_in_ready  | i_in_byte, i_new_message
//  output   | o_out_valid / i_out_ready| o_body_byte, o_body_valid, o_chunk_end,
//           |                          | o_message_done, o_error_code
//
// Every input transaction yields exactly one output transaction; the byte is held
// in the input register and then in the result register. One transaction per cycle
// is sustained while the output does not stall. The parser state and the result
// register are updated together when the byte moves on, so the one-byte state
// loop sets the rate. Reset (synchronous, active low) empties both registers and
// returns the parser to the start of a size line. When the output stalls, the input
// register keeps filling, so one more transaction is taken before o_in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module http_chunked_body_decoder #(
    parameter int LEN_BITS = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_new_message,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_body_byte,
    output logic            o_body_valid,
    output logic            o_chunk_end,
    output logic            o_message_done,
    output logic [2:0]      o_error_code
);
    import hcbd_pkg::*;

    // Parser phases. The size line runs LEAD -> NUM/XPRE -> EXT -> LINE_LF,
    // then DATA carries payload, SEP skips CR LF pairs between chunks, and
    // DONE/DONE_LF accept only CR LF pairs after the terminating chunk.
    typedef enum logic [3:0] {
        PH_LEAD    = 4'd0,
        PH_NUM     = 4'd1,
        PH_XPRE    = 4'd2,
        PH_EXT     = 4'd3,
        PH_LINE_LF = 4'd4,
        PH_DATA    = 4'd5,
        PH_SEP     = 4'd6,
        PH_SEP_LF  = 4'd7,
        PH_DONE    = 4'd8,
        PH_DONE_LF = 4'd9
    } t_phase;

    // Full parser state, so that sub-results can be formed and then selected.
    typedef struct packed {
        t_phase              phase;
        logic [LEN_BITS-1:0] count;
        logic                digit_seen;
        logic                zero_prefix;
        t_err                err;
    } t_state;

    // Input register.
    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_new;

    // Parser state.
    t_state              r_st;
    t_state              n_st;

    // Result register.
    logic                r_out_valid;
    logic [7:0]          r_body_byte;
    logic                r_body_valid;
    logic                r_chunk_end;
    logic                r_message_done;
    t_err                r_error_code;

    logic                n_body_valid;
    logic                n_chunk_end;

    logic                out_load;   // result register takes the buffered byte
    logic                in_load;    // input register takes a new transaction

    assign out_load   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || out_load;
    assign in_load    = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Per-byte parser step. A new message restarts from the reset state
    // before the byte is looked at.
    // ------------------------------------------------------------------
    t_state     cur;
    t_state     num_res;
    t_state     lead_res;
    t_hex       hx;
    logic [7:0] c;
    logic       ovf;
    logic       is_blank;
    logic       is_cr;
    logic       is_lf;
    logic [LEN_BITS-1:0] count_dec;

    always_comb begin
        c = r_in_byte;
        if (r_in_new) begin
            cur.phase       = PH_LEAD;
            cur.count       = '0;
            cur.digit_seen  = 1'b0;
            cur.zero_prefix = 1'b0;
            cur.err         = ERR_NONE;
        end else begin
            cur = r_st;
        end

        hx        = hex_digit(c);
        is_cr     = (c == CH_CR);
        is_lf     = (c == CH_LF);
        is_blank  = (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) ||
                    (c == CH_VT) || (c == CH_FF);
        // Another digit would push the size past LEN_BITS bits.
        ovf       = (cur.count[LEN_BITS-1 -: 4] != 4'd0);
        count_dec = cur.count - {{(LEN_BITS-1){1'b0}}, 1'b1};

        // A byte inside the number part of a size line.
        num_res = cur;
        if (hx.ok) begin
            num_res.zero_prefix = !cur.digit_seen && (c == CH_ZERO);
            num_res.digit_seen  = 1'b1;
            if (ovf) begin
                num_res.err = ERR_OVERFLOW;
            end else begin
                num_res.count = {cur.count[LEN_BITS-5:0], hx.val};
                num_res.phase = PH_NUM;
            end
        end else if ((c == CH_X_LO || c == CH_X_UP) && cur.zero_prefix) begin
            num_res.zero_prefix = 1'b0;
            num_res.phase       = PH_XPRE;
        end else if (is_cr) begin
            num_res.phase = PH_LINE_LF;
        end else begin
            num_res.phase = PH_EXT;
        end

        // A byte where leading blanks or a sign may still stand.
        lead_res = num_res;
        if (is_blank) begin
            lead_res       = cur;
            lead_res.phase = PH_LEAD;
        end else if (c == CH_MINUS) begin
            lead_res     = cur;
            lead_res.err = ERR_SIZE_LINE;
        end else if (c == CH_PLUS) begin
            lead_res       = cur;
            lead_res.phase = PH_NUM;
        end

        n_st         = cur;
        n_body_valid = 1'b0;
        n_chunk_end  = 1'b0;
        if (cur.err == ERR_NONE) begin
            case (cur.phase)
                PH_LEAD: begin
                    n_st = lead_res;
                end
                PH_NUM: begin
                    n_st = num_res;
                end
                PH_XPRE: begin
                    // After 0x only hex digits extend the size.
                    if (hx.ok) begin
                        if (ovf) begin
                            n_st.err = ERR_OVERFLOW;
                        end else begin
                            n_st.count = {cur.count[LEN_BITS-5:0], hx.val};
                            n_st.phase = PH_NUM;
                        end
                    end else if (is_cr) begin
                        n_st.phase = PH_LINE_LF;
                    end else begin
                        n_st.phase = PH_EXT;
                    end
                end
                PH_EXT: begin
                    if (is_cr) begin
                        n_st.phase = PH_LINE_LF;
                    end
                end
                PH_LINE_LF: begin
                    if (is_lf) begin
                        n_st.phase       = (cur.count == '0) ? PH_DONE : PH_DATA;
                        n_st.digit_seen  = 1'b0;
                        n_st.zero_prefix = 1'b0;
                    end else begin
                        n_st.err = ERR_SEPARATOR;
                    end
                end
                PH_DATA: begin
                    n_body_valid = 1'b1;
                    n_st.count   = count_dec;
                    if (count_dec == '0) begin
                        n_chunk_end = 1'b1;
                        n_st.phase  = PH_SEP;
                    end
                end
                PH_SEP: begin
                    // Anything but a CR opens the next size line.
                    if (is_cr) begin
                        n_st.phase = PH_SEP_LF;
                    end else begin
                        n_st = lead_res;
                    end
                end
                PH_SEP_LF: begin
                    if (is_lf) begin
                        n_st.phase = PH_SEP;
                    end else begin
                        n_st.err = ERR_SEPARATOR;
                    end
                end
                PH_DONE: begin
                    if (is_cr) begin
                        n_st.phase = PH_DONE_LF;
                    end else begin
                        n_st.err = ERR_AFTER_END;
                    end
                end
                PH_DONE_LF: begin
                    if (is_lf) begin
                        n_st.phase = PH_DONE;
                    end else begin
                        n_st.err = ERR_SEPARATOR;
                    end
                end
                default: begin
                    n_st.phase = PH_LEAD;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Registers. Payload registers load without reset; control and the
    // parser state are cleared by reset.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_byte <= i_in_byte;
            r_in_new  <= i_new_message;
        end
        if (out_load) begin
            r_body_byte    <= n_body_valid ? c : 8'd0;
            r_body_valid   <= n_body_valid;
            r_chunk_end    <= n_chunk_end;
            r_message_done <= (n_st.phase == PH_DONE) || (n_st.phase == PH_DONE_LF);
            r_error_code   <= n_st.err;
        end
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_st.phase       <= PH_LEAD;
            r_st.count       <= '0;
            r_st.digit_seen  <= 1'b0;
            r_st.zero_prefix <= 1'b0;
            r_st.err         <= ERR_NONE;
        end else begin
            if (in_load) begin
                r_in_valid <= 1'b1;
            end else if (out_load) begin
                r_in_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_st        <= n_st;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_body_byte    = r_body_byte;
    assign o_body_valid   = r_body_valid;
    assign o_chunk_end    = r_chunk_end;
    assign o_message_done = r_message_done;
    assign o_error_code   = r_error_code;

endmodule

`default_nettype wire

// ----- rtl/hcbd_checker.sv -----
// Port-level checks for http_chunked_body_decoder, attached by a bind below.
// Depends on hcbd_pkg for the error codes.
`timescale 1ns / 1ps
`default_nettype none

module hcbd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_body_byte,
    input wire logic       o_body_valid,
    input wire logic       o_chunk_end,
    input wire logic       o_message_done,
    input wire logic [2:0] o_error_code
);
    import hcbd_pkg::*;

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_body_byte) &&
        $stable(o_body_valid) && $stable(o_chunk_end) && $stable(o_error_code))
        else $error("result changed while stalled");

    // Only a payload byte can close a chunk, and idle bytes read as zero.
    a_chunk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_chunk_end || o_body_byte != 8'd0) |-> o_body_valid)
        else $error("chunk end or byte without payload");

    // Payload is never passed once an error or the end of the message is seen.
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_body_valid |-> o_error_code == ERR_NONE && !o_message_done)
        else $error("payload after error or end");

    // Error codes stay within the defined set.
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_error_code == ERR_NONE || o_error_code == ERR_SIZE_LINE ||
        o_error_code == ERR_OVERFLOW || o_error_code == ERR_SEPARATOR ||
        o_error_code == ERR_AFTER_END)
        else $error("undefined error code");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_body_byte    (o_body_byte),
    .o_body_valid   (o_body_valid),
    .o_chunk_end    (o_chunk_end),
    .o_message_done (o_message_done),
    .o_error_code   (o_error_code)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for http_chunked_body_decoder: byte stimulus, a cycle-free
// decoder model, and an in-order result checker. Depends on hcbd_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_top;
    import hcbd_pkg::*;

    localparam int LEN_BITS = 32;

    // Parser states of the decoder model. They follow the layout of a chunked body:
    // size line, its line end, payload, separators and the trailer after the last chunk.
    typedef enum logic [3:0] {
        ST_LEAD,
        ST_NUM,
        ST_XPRE,
        ST_EXT,
        ST_LINE_LF,
        ST_DATA,
        ST_SEP,
        ST_SEP_LF,
        ST_DONE,
        ST_DONE_LF
    } t_parse_st;

    // One output transaction of the decoder.
    typedef struct packed {
        logic [7:0] data;
        logic       data_vld;
        logic       last;
        logic       done;
        t_err       err;
    } t_body_res;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_in_byte     = 8'h00;
    logic       i_new_message = 1'b0;
    logic       i_out_ready   = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_body_byte;
    logic       o_body_valid;
    logic       o_chunk_end;
    logic       o_message_done;
    logic [2:0] o_error_code;

    http_chunked_body_decoder #(
        .LEN_BITS(LEN_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_new_message (i_new_message),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_body_byte   (o_body_byte),
        .o_body_valid  (o_body_valid),
        .o_chunk_end   (o_chunk_end),
        .o_message_done(o_message_done),
        .o_error_code  (o_error_code)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Decoder model state. It is advanced once per accepted input
    // transaction, in the same order the block sees the bytes.
    // ------------------------------------------------------------------
    t_parse_st             parse_st;
    logic [LEN_BITS-1:0]   chunk_left;
    logic                  got_digit;
    logic                  lone_zero;   // the only digit of the line so far is a leading 0
    t_err                  sticky_err;

    t_body_res decoded_q[$];            // predicted results still waiting for the output
    int        mismatches = 0;
    int        items_sent = 0;

    // Traffic shaping, changed by the test tasks.
    int   tx_idle_pct = 15;
    int   rx_idle_pct = 48;
    logic rx_hold     = 1'b0;
    logic msg_start   = 1'b0;           // next byte opens a message and carries new_message
    logic mangle      = 1'b0;           // corrupt the current message at random

    function automatic void clear_decoder();
        parse_st   = ST_LEAD;
        chunk_left = '0;
        got_digit  = 1'b0;
        lone_zero  = 1'b0;
        sticky_err = ERR_NONE;
    endfunction

    // Returns {is_hex, value} for one ASCII character.
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return {1'b1, 4'(c - CH_ZERO)};
        if (c >= CH_A_LO && c <= CH_F_LO) return {1'b1, 4'(c - CH_A_LO + 8'd10)};
        if (c >= CH_A_UP && c <= CH_F_UP) return {1'b1, 4'(c - CH_A_UP + 8'd10)};
        return 5'd0;
    endfunction

    // Shifts one hex digit into the chunk size unless the size would no longer fit.
    function automatic void push_nibble(input logic [3:0] d);
        if (chunk_left[LEN_BITS-1 -: 4] != 4'd0) begin
            sticky_err = ERR_OVERFLOW;
        end else begin
            chunk_left = {chunk_left[LEN_BITS-5:0], d};
            parse_st   = ST_NUM;
        end
    endfunction

    function automatic void size_char(input logic [7:0] c);
        logic [4:0] h;
        h = hex_of(c);
        if (h[4]) begin
            lone_zero = !got_digit && c == CH_ZERO;
            got_digit = 1'b1;
            push_nibble(h[3:0]);
        end else if ((c == CH_X_LO || c == CH_X_UP) && lone_zero) begin
            lone_zero = 1'b0;
            parse_st  = ST_XPRE;
        end else if (c == CH_CR) begin
            parse_st = ST_LINE_LF;
        end else begin
            parse_st = ST_EXT;
        end
    endfunction

    // First characters of a size line: blanks are skipped, a minus is fatal and a
    // plus sign only moves on to the number.
    function automatic void line_start_char(input logic [7:0] c);
        if (c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF) begin
            parse_st = ST_LEAD;
        end else if (c == CH_MINUS) begin
            sticky_err = ERR_SIZE_LINE;
        end else if (c == CH_PLUS) begin
            parse_st = ST_NUM;
        end else begin
            size_char(c);
        end
    endfunction

    // Advances the model by one byte and returns the result the block must give for it.
    function automatic t_body_res decode_byte(input logic [7:0] c, input logic nm);
        t_body_res  r;
        logic [4:0] h;
        r = '0;
        if (nm) clear_decoder();
        if (sticky_err == ERR_NONE) begin
            case (parse_st)
                ST_LEAD: line_start_char(c);
                ST_NUM:  size_char(c);
                ST_XPRE: begin
                    h = hex_of(c);
                    if (h[4]) push_nibble(h[3:0]);
                    else if (c == CH_CR) parse_st = ST_LINE_LF;
                    else parse_st = ST_EXT;
                end
                ST_EXT: begin
                    if (c == CH_CR) parse_st = ST_LINE_LF;
                end
                ST_LINE_LF: begin
                    if (c == CH_LF) begin
                        parse_st  = (chunk_left == '0) ? ST_DONE : ST_DATA;
                        got_digit = 1'b0;
                        lone_zero = 1'b0;
                    end else begin
                        sticky_err = ERR_SEPARATOR;
                    end
                end
                ST_DATA: begin
                    r.data_vld = 1'b1;
                    chunk_left = chunk_left - 1'b1;
                    if (chunk_left == '0) begin
                        r.last   = 1'b1;
                        parse_st = ST_SEP;
                    end
                end
                ST_SEP: begin
                    if (c == CH_CR) parse_st = ST_SEP_LF;
                    else line_start_char(c);
                end
                ST_SEP_LF: begin
                    if (c == CH_LF) parse_st = ST_SEP;
                    else sticky_err = ERR_SEPARATOR;
                end
                ST_DONE: begin
                    if (c == CH_CR) parse_st = ST_DONE_LF;
                    else sticky_err = ERR_AFTER_END;
                end
                ST_DONE_LF: begin
                    if (c == CH_LF) parse_st = ST_DONE;
                    else sticky_err = ERR_SEPARATOR;
                end
                default: parse_st = ST_LEAD;
            endcase
        end
        r.data = r.data_vld ? c : 8'h00;
        r.done = parse_st == ST_DONE || parse_st == ST_DONE_LF;
        r.err  = sticky_err;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking. Predictions are queued at the edge that accepts an
    // input transaction; each output transaction is matched to the oldest.
    // ------------------------------------------------------------------
    function automatic void log_mismatch(input string why, input t_body_res want);
        mismatches++;
        if (mismatches <= 10) begin
            $write("%0t %s: expected byte=%h valid=%b end=%b done=%b err=%0d, ",
                   $time, why, want.data, want.data_vld, want.last, want.done, want.err);
            $display("got byte=%h valid=%b end=%b done=%b err=%0d",
                     o_body_byte, o_body_valid, o_chunk_end, o_message_done, o_error_code);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_body_res want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                decoded_q.push_back(decode_byte(i_in_byte, i_new_message));
            end
            if (o_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    log_mismatch("unexpected result", '0);
                end else begin
                    want = decoded_q.pop_front();
                    if (want.data != o_body_byte || want.data_vld != o_body_valid ||
                        want.last != o_chunk_end || want.done != o_message_done ||
                        want.err != o_error_code) begin
                        log_mismatch("mismatch", want);
                    end
                end
            end
        end
    end

    // The receiver stalls at random, or for as long as rx_hold is raised.
    always @(negedge i_clk) begin
        i_out_ready = rx_hold ? 1'b0 : ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------
    // Sending. Every task below is entered just after a falling edge and
    // returns just after one, so inputs only ever move at falling edges.
    // ------------------------------------------------------------------

    // Offers one byte and waits until the block takes it. Valid may drop for a few
    // idle cycles before the byte, never while it is being offered.
    task automatic put_byte(input logic [7:0] b);
        logic [7:0] v;
        logic       nm;
        v  = b;
        nm = msg_start;
        if (mangle) begin
            // Corrupted messages get stray bytes and the odd mid-stream restart.
            if ($urandom_range(0, 24) == 0) v = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) == 0) nm = 1'b1;
        end
        msg_start = 1'b0;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_in_byte     = v;
        i_new_message = nm;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic put_crlf();
        put_byte(CH_CR);
        put_byte(CH_LF);
    endtask

    // Holds off the sender until every predicted result has come out.
    task automatic drain_results();
        i_in_valid = 1'b0;
        for (int w = 0; w < 50000 && decoded_q.size() != 0; w++) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Builds one chunked message with random layout and payload. Most messages are
    // well formed so that payload and trailer states get exercised; some are
    // corrupted and a few are pure noise.
    task automatic gen_message();
        logic [7:0]  b;
        logic [3:0]  nib;
        logic [31:0] sz;
        logic        upper;
        int          nchunks;
        int          ndig;
        msg_start = 1'b1;
        mangle    = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(4, 16)) put_byte(8'($urandom_range(0, 255)));
            return;
        end
        nchunks = $urandom_range(0, 3);
        // The pass with k equal to nchunks writes the zero-size last-chunk line.
        for (int k = 0; k <= nchunks; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 2)) begin
                    case ($urandom_range(0, 4))
                        0:       b = CH_SP;
                        1:       b = CH_TAB;
                        2:       b = CH_LF;
                        3:       b = CH_VT;
                        default: b = CH_FF;
                    endcase
                    put_byte(b);
                end
            end
            if ($urandom_range(0, 5) == 0) put_byte(CH_PLUS);
            if (k == nchunks) sz = 0;
            else if ($urandom_range(0, 19) == 0) sz = $urandom_range(200, 300);
            else if ($urandom_range(0, 9) == 0) sz = $urandom_range(7, 40);
            else sz = $urandom_range(1, 6);
            case ($urandom_range(0, 3))
                0: begin
                    put_byte(CH_ZERO);
                    put_byte($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
                end
                1: repeat ($urandom_range(1, 2)) put_byte(CH_ZERO);
                default: ;
            endcase
            // Size digits, most significant first, in a random mix of cases. A
            // zero size writes no digits at all, which still counts as zero.
            ndig = 0;
            for (logic [31:0] t = sz; t != 0; t = t >> 4) ndig++;
            for (int i = ndig - 1; i >= 0; i--) begin
                nib   = sz[4*i +: 4];
                upper = $urandom_range(0, 1);
                if (nib < 4'd10) put_byte(CH_ZERO + 8'(nib));
                else put_byte((upper ? CH_A_UP : CH_A_LO) + 8'(nib) - 8'd10);
            end
            if ($urandom_range(0, 3) == 0) begin
                put_byte(8'h3b);
                repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(8'h21, 8'h7e)));
            end
            put_crlf();
            if (k < nchunks) begin
                repeat (sz) put_byte(8'($urandom_range(0, 255)));
                // Usually one CR LF after the payload, sometimes extra ones or none.
                if ($urandom_range(0, 9) != 0) put_crlf();
                if ($urandom_range(0, 4) == 0) put_crlf();
            end
        end
        repeat ($urandom_range(0, 2)) put_crlf();
        if (mangle && $urandom_range(0, 1)) put_byte(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short hand-written messages, each opened with new_message.
    task automatic test_directed();
        mangle = 1'b0;
        // Leading blank, 0x prefix, payload bytes at both extremes, a spare CR LF
        // between chunks, a plus sign with an extension that holds a minus, the last
        // chunk, a CR LF after it, and then a stray byte after the end.
        msg_start = 1'b1;
        send_text(" 0x2");
        put_crlf();
        put_byte(8'h00);
        put_byte(8'hff);
        put_crlf();
        put_crlf();
        put_byte(CH_TAB);
        send_text("+0;-x");
        put_crlf();
        put_crlf();
        send_text("Z");
        // A minus where the sign stands is a bad size line, and the error sticks.
        msg_start = 1'b1;
        send_text("-5");
        // Eight digits of all ones fit; a ninth digit overflows.
        msg_start = 1'b1;
        send_text("FfFfFfFf0");
        // A CR without its LF at the end of a size line.
        msg_start = 1'b1;
        send_text("1");
        put_byte(CH_CR);
        send_text("X");
        // 0X with no digit after it is size zero; then a lone CR after the end.
        msg_start = 1'b1;
        send_text("0Xg");
        put_crlf();
        put_byte(CH_CR);
        put_byte(CH_CR);
        // A lone CR between chunks.
        msg_start = 1'b1;
        send_text("1");
        put_crlf();
        send_text("Q");
        put_byte(CH_CR);
        put_byte(8'h00);
    endtask

    task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
        int target;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target      = items_sent + n_items;
        while (items_sent < target) gen_message();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // bytes back to back, so the block fills up and has to stall its input.
    task automatic test_output_stall();
        int target;
        tx_idle_pct = 0;
        rx_idle_pct = 10;
        target      = items_sent + 40;
        fork
            begin
                rx_hold = 1'b1;
                repeat (200) @(negedge i_clk);
                rx_hold = 1'b0;
            end
            while (items_sent < target) gen_message();
        join
    endtask

    initial begin
        clear_decoder();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        drain_results();
        test_random_traffic(300, 15, 48);
        drain_results();
        test_random_traffic(300, 48, 15);
        drain_results();
        test_output_stall();
        drain_results();
        test_random_traffic(300, 0, 0);

        // Let the last results out, then give the pipeline a few more cycles so a
        // spurious extra transaction would still be caught.
        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/hcbd_pkg.sv
rtl/http_chunked_body_decoder.sv
rtl/hcbd_checker.sv
tb/tb_top.sv
